/* rtl/core/pctt_pkg.sv */
// ----------------------------------------------------------------------------
// pctt_pkg
// types and codes shared by the command timer table
// ----------------------------------------------------------------------------
`default_nettype none
package pctt_pkg;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_SCHED  = 3'd1,
		OP_CANCEL = 3'd2,
		OP_QUERY  = 3'd3,
		OP_FG     = 3'd4,
		OP_LIGHT  = 3'd5
	} op_e;

	localparam logic [1:0] MODE_OBJ  = 2'd0;
	localparam logic [1:0] MODE_OP   = 2'd1;
	localparam logic [1:0] MODE_TYPE = 2'd2;

	localparam logic [1:0] KIND_DONE  = 2'd0;
	localparam logic [1:0] KIND_FIRED = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;
	localparam logic [1:0] KIND_FULL  = 2'd3;

	localparam logic [1:0] LIGHT_OFF  = 2'd0;
	localparam logic [1:0] LIGHT_KEEP = 2'd3;

	// most fired results caused by one item
	localparam int MAX_RESULTS = 16;

	typedef struct packed {
		logic [2:0]         operation;
		logic [1:0]         match_mode;
		logic [15:0]        object_id;
		logic [7:0]         op_code;
		logic [3:0]         cmd_type;
		logic signed [31:0] param;
		logic               has_object;
		logic [19:0]        delay_ms;
		logic [15:0]        cmd_tag;
		logic               foreground;
		logic [1:0]         light_target;
		logic [1:0]         light_status;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] fired_tag;
		logic [19:0] time_left;
		logic        found;
		logic        last;
	} out_item_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] obj;
		logic        has_obj;
		logic [7:0]  opcode;
		logic [3:0]  ctype;
		logic [31:0] param;
		logic [19:0] remaining;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT,
		ST_SCHED,
		ST_DONE
	} state_e;

endpackage
`default_nettype wire

/* rtl/core/pctt_mem.sv */
// ----------------------------------------------------------------------------
// pctt_mem
// entry storage, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module pctt_mem
	import pctt_pkg::*;
#(
	parameter int Depth = 16,
	parameter int AW = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire entry_t        wdata,
	input  wire logic [AW-1:0] raddr,
	output entry_t             rdata
);

	entry_t mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/core/pausable_command_timer_table_unit.sv */
// ----------------------------------------------------------------------------
// pausable_command_timer_table_unit
// table of delayed commands with pausable countdown, cancel and query
// ----------------------------------------------------------------------------
// sequence: done, rejected and immediate-fire items pass through the done state
//   to the output register, a stored schedule goes through the schedule state
//   first; tick, cancel, query and resume walk every slot, then emit
// throughput: one item at a time, the next accepted after the final result is
//   loaded; a blocked result output stalls the walk or the final result
// reset: all slots invalid, foreground and primary light on, running
// ----------------------------------------------------------------------------
`default_nettype none
module pausable_command_timer_table_unit
	import pctt_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data,
	input  wire logic      cfg_valid,
	output logic           cfg_ready,
	input  wire logic [3:0] cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int NFW = $clog2(((TABLE_DEPTH > MAX_RESULTS) ? TABLE_DEPTH :
		MAX_RESULTS) + 1);

	// control state
	state_e           state_q, state_d;
	in_item_t         item_q;
	logic [3:0]       cust_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic             fg_q, prim_q, sec_q, run_q;
	logic [AW:0]      idx_q;        // address being read
	logic             rd_pend_q;    // read data returns this cycle
	logic [AW-1:0]    rd_idx_q;     // slot of the returning data
	logic             fire_q;       // walk fires due entries
	logic             dec_q;        // walk counts entries down
	logic             any_q;        // something stored or fired in this item
	logic [NFW-1:0]   nfired_q;
	logic             found_q;
	logic [19:0]      best_q;
	logic             ovalid_q;
	out_item_t        odata_q;
	logic             hold_v_q;     // a fired item waits for its last flag
	logic [15:0]      hold_tag_q;

	// memory
	logic             mwe;
	logic [AW-1:0]    mwaddr;
	entry_t           mwdata;
	entry_t           mrdata;

	pctt_mem #(.Depth(TABLE_DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mwe),
		.waddr (mwaddr),
		.wdata (mwdata),
		.raddr (idx_q[AW-1:0]),
		.rdata (mrdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	wire logic out_free = !ovalid_q || out_ready;

	// lowest free slot
	logic          free_any;
	logic [AW-1:0] free_idx;
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = AW'(i);
			end
		end
	end

	// running evaluation for foreground/light items
	logic nfg, nprim, nsec, want;
	always_comb begin
		nfg = fg_q;
		nprim = prim_q;
		nsec = sec_q;
		if (in_data.operation == OP_FG) begin
			nfg = in_data.foreground;
		end
		if (in_data.operation == OP_LIGHT && in_data.light_status != LIGHT_KEEP) begin
			if (in_data.light_target[0]) nprim = (in_data.light_status != LIGHT_OFF);
			if (in_data.light_target[1]) nsec = (in_data.light_status != LIGHT_OFF);
		end
		want = (nprim || nsec) && nfg;
	end

	// evaluation of the returned entry
	entry_t     e;
	logic       e_valid, e_match, e_due;
	logic [19:0] e_rem;
	logic       walking_data;
	always_comb begin
		e = mrdata;
		e_valid = valid_q[rd_idx_q];
		e_match = e_valid && e.has_obj && (e.obj == item_q.object_id);
		case (item_q.match_mode)
			MODE_OBJ: ;
			MODE_OP:  e_match = e_match && (e.opcode == item_q.op_code);
			MODE_TYPE: e_match = e_match && (e.ctype == item_q.cmd_type) &&
				(item_q.cmd_type != cust_q || e.param == item_q.param);
			default:  e_match = 1'b0;
		endcase
		e_rem = (dec_q && e.remaining != '0) ? e.remaining - 20'd1 : e.remaining;
		e_due = e_valid && fire_q && (e_rem == '0) &&
			(nfired_q < NFW'(MAX_RESULTS));
		walking_data = (state_q == ST_WALK) && rd_pend_q;
	end

	// walk stalls when a held fire result must go out and the output is busy
	wire logic stall = walking_data && e_due && hold_v_q && !out_free;

	always_comb begin
		mwe = 1'b0;
		mwaddr = rd_idx_q;
		mwdata = e;
		if (state_q == ST_SCHED) begin
			mwe = 1'b1;
			mwaddr = free_idx;
			mwdata.tag = item_q.cmd_tag;
			mwdata.obj = item_q.object_id;
			mwdata.has_obj = item_q.has_object;
			mwdata.opcode = item_q.op_code;
			mwdata.ctype = item_q.cmd_type;
			mwdata.param = item_q.param;
			mwdata.remaining = item_q.delay_ms;
		end else if (walking_data && dec_q && e_valid && !stall) begin
			mwe = 1'b1;
			mwdata.remaining = e_rem;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) begin
				case (in_data.operation)
					OP_TICK:   state_d = run_q ? ST_WALK : ST_DONE;
					OP_SCHED:  state_d = (in_data.delay_ms == '0 || !free_any) ?
						ST_DONE : ST_SCHED;
					OP_CANCEL, OP_QUERY: state_d = ST_WALK;
					OP_FG, OP_LIGHT: state_d = (want && !run_q) ? ST_WALK : ST_DONE;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_SCHED: state_d = ST_DONE;
			ST_WALK: if (walking_data && !stall &&
					rd_idx_q == AW'(TABLE_DEPTH - 1)) begin
				state_d = ST_EMIT;
			end
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// final result when no fired item is held, and fired results from the hold register
	out_item_t done_res, emit_res, last_res;
	always_comb begin
		done_res = '0;
		done_res.last = 1'b1;
		if (item_q.operation == OP_SCHED) begin
			if (item_q.delay_ms == '0) begin
				done_res.result_kind = KIND_FIRED;
				done_res.fired_tag = item_q.cmd_tag;
			end else if (!any_q) begin
				done_res.result_kind = KIND_FULL;
			end
		end
		if (item_q.operation == OP_QUERY) begin
			done_res.result_kind = KIND_QUERY;
			done_res.time_left = best_q;
			done_res.found = found_q;
		end
		emit_res = '0;
		emit_res.result_kind = KIND_FIRED;
		emit_res.fired_tag = hold_tag_q;
		last_res = emit_res;
		last_res.last = 1'b1;
	end

	// output register load: a held fired item goes out when the next one is due;
	// in emit or done the final result goes out, a held fired one flagged last
	logic      o_load;
	out_item_t o_next;
	always_comb begin
		o_load = 1'b0;
		o_next = done_res;
		case (state_q)
			ST_WALK: if (walking_data && e_due && hold_v_q && !stall) begin
				o_load = 1'b1;
				o_next = emit_res;
			end
			ST_EMIT, ST_DONE: if (out_free) begin
				o_load = 1'b1;
				o_next = hold_v_q ? last_res : done_res;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cust_q <= '0;
			valid_q <= '0;
			fg_q <= 1'b1;
			prim_q <= 1'b1;
			sec_q <= 1'b0;
			run_q <= 1'b1;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			rd_idx_q <= '0;
			fire_q <= 1'b0;
			dec_q <= 1'b0;
			any_q <= 1'b0;
			nfired_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			ovalid_q <= 1'b0;
			odata_q <= '0;
			item_q <= '0;
			hold_v_q <= 1'b0;
			hold_tag_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) cust_q <= cfg_data;
			if (o_load) begin
				ovalid_q <= 1'b1;
				odata_q <= o_next;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_valid) begin
					item_q <= in_data;
					idx_q <= '0;
					rd_pend_q <= 1'b0;
					nfired_q <= '0;
					found_q <= 1'b0;
					best_q <= '0;
					any_q <= 1'b0;
					hold_v_q <= 1'b0;
					fire_q <= (in_data.operation == OP_TICK) ||
						(in_data.operation == OP_FG) || (in_data.operation == OP_LIGHT);
					dec_q <= (in_data.operation == OP_TICK);
					if (in_data.operation == OP_FG || in_data.operation == OP_LIGHT) begin
						fg_q <= nfg;
						prim_q <= nprim;
						sec_q <= nsec;
						run_q <= want;
					end
				end
				ST_SCHED: begin
					valid_q[free_idx] <= 1'b1;
					any_q <= 1'b1;
				end
				ST_WALK: if (!stall) begin
					// issue next read while consuming the previous one
					if (idx_q < (AW+1)'(TABLE_DEPTH)) begin
						idx_q <= idx_q + 1'b1;
						rd_pend_q <= 1'b1;
						rd_idx_q <= idx_q[AW-1:0];
					end else begin
						rd_pend_q <= 1'b0;
					end
					if (walking_data) begin
						if (item_q.operation == OP_CANCEL && e_match)
							valid_q[rd_idx_q] <= 1'b0;
						if (item_q.operation == OP_QUERY && e_match) begin
							found_q <= 1'b1;
							if (!found_q || e.remaining < best_q) best_q <= e.remaining;
						end
						if (e_due) begin
							valid_q[rd_idx_q] <= 1'b0;
							nfired_q <= nfired_q + 1'b1;
							any_q <= 1'b1;
							hold_v_q <= 1'b1;
							hold_tag_q <= e.tag;
						end
					end
				end else begin
					// hold read address so data reappears after the stall
					idx_q <= {1'b0, rd_idx_q};
					rd_pend_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	a_sched_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCHED |=> state_q == ST_DONE)
		else $error("schedule sequence broken");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// drives items into the command timer table and checks every result against
// a behavioral table model; runs directed tests, then random traffic under
// several idling patterns and custom type settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb
	import pctt_pkg::*;
();

	localparam int DEPTH = 16;
	localparam int MAX_FIRE = 16;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_item_t in_data;
	logic out_valid;
	logic out_ready;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [3:0] cfg_data;

	pausable_command_timer_table_unit #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// model of the table, kept in step with accepted items
	logic              tbl_valid [DEPTH];
	entry_t            tbl_entry [DEPTH];
	logic              fg_on, prim_on, sec_on, run_on;
	logic [3:0]        custom_type;

	out_item_t         pending_results[$];
	int                error_count;
	int                send_idle_pct;
	int                recv_idle_pct;

	// fire entries at zero in slot order, capped per item
	function automatic void fire_due_entries();
		int fired;
		fired = 0;
		for (int i = 0; i < DEPTH; i++) begin
			if (fired < MAX_FIRE && tbl_valid[i] && tbl_entry[i].remaining == 0) begin
				pending_results.push_back('{KIND_FIRED, tbl_entry[i].tag, 20'd0, 1'b0,
					1'b0});
				tbl_valid[i] = 1'b0;
				fired++;
			end
		end
	endfunction

	function automatic logic entry_matches(int i, in_item_t it);
		if (!tbl_valid[i] || !tbl_entry[i].has_obj || tbl_entry[i].obj != it.object_id)
			return 1'b0;
		case (it.match_mode)
			MODE_OBJ:  return 1'b1;
			MODE_OP:   return tbl_entry[i].opcode == it.op_code;
			MODE_TYPE: begin
				if (tbl_entry[i].ctype != it.cmd_type)
					return 1'b0;
				if (it.cmd_type == custom_type && tbl_entry[i].param != it.param)
					return 1'b0;
				return 1'b1;
			end
			default:   return 1'b0;
		endcase
	endfunction

	function automatic void reevaluate_running();
		logic want;
		want = (prim_on || sec_on) && fg_on;
		if (!want)
			run_on = 1'b0;
		else if (!run_on) begin
			run_on = 1'b1;
			fire_due_entries();
		end
	endfunction

	// expected results for one accepted item, appended to the queue
	function automatic void predict_table_results(in_item_t it);
		int before_n;
		int slot;
		logic hit;
		logic [19:0] best;
		out_item_t r;
		before_n = pending_results.size();
		case (it.operation)
			OP_TICK: if (run_on) begin
				for (int i = 0; i < DEPTH; i++)
					if (tbl_valid[i] && tbl_entry[i].remaining != 0)
						tbl_entry[i].remaining--;
				fire_due_entries();
			end
			OP_SCHED: begin
				if (it.delay_ms == 0)
					pending_results.push_back('{KIND_FIRED, it.cmd_tag, 20'd0, 1'b0, 1'b0});
				else begin
					slot = -1;
					for (int i = DEPTH - 1; i >= 0; i--)
						if (!tbl_valid[i])
							slot = i;
					if (slot < 0)
						pending_results.push_back('{KIND_FULL, 16'd0, 20'd0, 1'b0, 1'b0});
					else begin
						tbl_valid[slot] = 1'b1;
						tbl_entry[slot] = '{it.cmd_tag, it.object_id, it.has_object,
							it.op_code, it.cmd_type, it.param, it.delay_ms};
					end
				end
			end
			OP_CANCEL:
				for (int i = 0; i < DEPTH; i++)
					if (entry_matches(i, it))
						tbl_valid[i] = 1'b0;
			OP_QUERY: begin
				hit = 1'b0;
				best = '0;
				for (int i = 0; i < DEPTH; i++)
					if (entry_matches(i, it)) begin
						if (!hit || tbl_entry[i].remaining < best)
							best = tbl_entry[i].remaining;
						hit = 1'b1;
					end
				pending_results.push_back('{KIND_QUERY, 16'd0, best, hit, 1'b0});
			end
			OP_FG: begin
				fg_on = it.foreground;
				reevaluate_running();
			end
			OP_LIGHT: begin
				if (it.light_status != LIGHT_KEEP) begin
					if (it.light_target[0])
						prim_on = it.light_status != LIGHT_OFF;
					if (it.light_target[1])
						sec_on = it.light_status != LIGHT_OFF;
				end
				reevaluate_running();
			end
			default: ;
		endcase
		if (pending_results.size() == before_n)
			pending_results.push_back('{KIND_DONE, 16'd0, 20'd0, 1'b0, 1'b0});
		r = pending_results[$];
		r.last = 1'b1;
		pending_results[$] = r;
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with nothing expected: %p", out_data);
					error_count++;
				end else begin
					want = pending_results.pop_front();
					if (out_data.result_kind !== want.result_kind) begin
						$error("result_kind expected %0d got %0d", want.result_kind,
							out_data.result_kind);
						error_count++;
					end
					if (out_data.fired_tag !== want.fired_tag) begin
						$error("fired_tag expected %0h got %0h", want.fired_tag,
							out_data.fired_tag);
						error_count++;
					end
					if (out_data.time_left !== want.time_left) begin
						$error("time_left expected %0d got %0d", want.time_left,
							out_data.time_left);
						error_count++;
					end
					if (out_data.found !== want.found) begin
						$error("found expected %0b got %0b", want.found, out_data.found);
						error_count++;
					end
					if (out_data.last !== want.last) begin
						$error("last expected %0b got %0b", want.last, out_data.last);
						error_count++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < send_idle_pct)
			@(posedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_table_results(it);
		in_valid <= 1'b0;
		// the unit is not ready in the cycle after it takes an item
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
	endtask

	task automatic write_custom_type(logic [3:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		custom_type = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic in_item_t random_item();
		in_item_t it;
		logic [127:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom};
		it = bits[$bits(in_item_t)-1:0];
		it.operation = 3'($urandom_range(7));
		it.match_mode = 2'($urandom_range(3));
		return it;
	endfunction

	function automatic in_item_t make_sched(logic [15:0] obj, logic [19:0] dly,
		logic [15:0] tg);
		in_item_t it;
		it = random_item();
		it.operation = OP_SCHED;
		it.object_id = obj;
		it.delay_ms = dly;
		it.cmd_tag = tg;
		it.has_object = 1'b1;
		return it;
	endfunction

	function automatic in_item_t make_op(op_e op);
		in_item_t it;
		it = random_item();
		it.operation = op;
		return it;
	endfunction

	// extremes, every operation, pause and resume, full table and its overflow
	task automatic test_directed();
		in_item_t it;
		send_item(make_sched(16'hffff, 20'd0, 16'hffff));
		it = make_sched(16'h0000, 20'hfffff, 16'h0000);
		it.param = 32'sh7fffffff;
		it.op_code = 8'hff;
		it.cmd_type = 4'hf;
		send_item(it);
		it.match_mode = MODE_TYPE;
		it.operation = OP_QUERY;
		send_item(it);
		it.param = 32'sh80000000;
		send_item(it);
		it.match_mode = 2'd3;
		send_item(it);
		it.match_mode = MODE_OP;
		it.operation = OP_CANCEL;
		send_item(it);
		it = make_op(OP_TICK);
		send_item(it);
		it.operation = 3'd6;
		send_item(it);
		it.operation = 3'd7;
		send_item(it);
		// pause with foreground off, schedule, tick, resume
		it = make_op(OP_FG);
		it.foreground = 1'b0;
		send_item(it);
		send_item(make_sched(16'h0012, 20'd1, 16'h1111));
		send_item(make_sched(16'h0012, 20'd0, 16'h2222));
		send_item(make_op(OP_TICK));
		it.foreground = 1'b1;
		send_item(it);
		// fill all slots with delay one, overflow, then fire together
		for (int i = 0; i < DEPTH; i++)
			send_item(make_sched(16'(i), 20'd1, 16'(16'h100 + i)));
		send_item(make_sched(16'h0001, 20'd5, 16'hbeef));
		it = make_op(OP_LIGHT);
		it.light_target = 2'b11;
		it.light_status = LIGHT_OFF;
		send_item(it);
		send_item(make_op(OP_TICK));
		it.light_target = 2'b10;
		it.light_status = 2'd2;
		send_item(it);
		it.light_status = LIGHT_KEEP;
		send_item(it);
		send_item(make_op(OP_TICK));
	endtask

	// schedule-heavy mix with a small object range so matches hit
	task automatic test_random(int count);
		in_item_t it;
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			it = random_item();
			it.object_id = (pick < 80) ? 16'($urandom_range(3)) : it.object_id;
			it.op_code = (pick < 60) ? 8'($urandom_range(2)) : it.op_code;
			it.cmd_type = (pick < 60) ? 4'($urandom_range(2)) : it.cmd_type;
			it.param = (pick < 50) ? 32'($urandom_range(1)) : it.param;
			if (pick < 30) begin
				it.operation = OP_SCHED;
				it.delay_ms = ($urandom_range(9) == 0) ? it.delay_ms
					: 20'($urandom_range(6));
			end else if (pick < 55)
				it.operation = OP_TICK;
			else if (pick < 85)
				it.operation = ($urandom_range(1) == 0) ? OP_CANCEL : OP_QUERY;
			else if (pick < 93)
				it.operation = $urandom_range(1) ? OP_FG : OP_LIGHT;
			send_item(it);
		end
	endtask

	// sender holds off until every result is in, then continues
	task automatic test_hold_off();
		send_item(make_sched(16'h0003, 20'd2, 16'h3333));
		wait_drained();
		send_item(make_op(OP_TICK));
		send_item(make_op(OP_TICK));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		error_count = 0;
		send_idle_pct = 36;
		recv_idle_pct = 78;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_entry[i] = '0;
		end
		fg_on = 1'b1;
		prim_on = 1'b1;
		sec_on = 1'b0;
		run_on = 1'b1;
		custom_type = 4'd0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_custom_type(4'd1);
		test_random(63);
		test_hold_off();
		send_idle_pct = 78;
		recv_idle_pct = 36;
		write_custom_type(4'd15);
		test_random(63);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_custom_type(4'd0);
		test_random(63);
		wait_drained();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
